// File: rtl/core/frba_pkg.sv
package frba_pkg;

  localparam int unsigned ALIGN_W   = 13;
  localparam int unsigned SIZE_W    = 21;
  localparam int unsigned HANDLE_W  = 22;
  localparam int unsigned SLOT_O_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_SHRINK = 2'd1,
    OP_SWAP   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_INDEX    = 2'd1,
    KIND_CONSTANT = 2'd2,
    KIND_CUSTOM   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_SHRINK   = 2'd2
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_ALIGN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_ALIGN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_ALIGN = 2'd2;

  localparam logic [ALIGN_W-1:0] VERTEX_ALIGN_RST   = 13'd32;
  localparam logic [ALIGN_W-1:0] INDEX_ALIGN_RST    = 13'd16;
  localparam logic [ALIGN_W-1:0] CONSTANT_ALIGN_RST = 13'd256;

  typedef struct packed {
    logic [ALIGN_W-1:0] vertex_align;
    logic [ALIGN_W-1:0] index_align;
    logic [ALIGN_W-1:0] constant_align;
  } align_cfg_t;

  typedef struct packed {
    op_e                op;
    kind_e              align_kind;
    logic [ALIGN_W-1:0] custom_align;
    logic [SIZE_W-1:0]  size_bytes;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_offset;
    status_e             status;
    logic [SLOT_O_W-1:0] frame_slot;
    logic [SIZE_W-1:0]   fill_bytes;
    logic [SIZE_W-1:0]   peak_bytes;
    logic [SIZE_W-1:0]   alloc_count;
  } res_t;

endpackage

// File: rtl/core/frba_cfg_regs.sv
module frba_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [frba_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [frba_pkg::ALIGN_W-1:0]     cfg_wdata_i,
  output frba_pkg::align_cfg_t             cfg_o
);

  frba_pkg::align_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        frba_pkg::CFG_VERTEX_ALIGN:   cfg_d.vertex_align   = cfg_wdata_i;
        frba_pkg::CFG_INDEX_ALIGN:    cfg_d.index_align    = cfg_wdata_i;
        frba_pkg::CFG_CONSTANT_ALIGN: cfg_d.constant_align = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vertex_align   <= frba_pkg::VERTEX_ALIGN_RST;
      cfg_q.index_align    <= frba_pkg::INDEX_ALIGN_RST;
      cfg_q.constant_align <= frba_pkg::CONSTANT_ALIGN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/frba_step_logic.sv
module frba_step_logic #(
  parameter int unsigned REGION_BYTES = 1048576,
  parameter int unsigned REGION_COUNT = 3,
  localparam int unsigned FILL_W = $clog2(REGION_BYTES + 1),
  localparam int unsigned SLOT_W = $clog2(REGION_COUNT)
) (
  input  frba_pkg::req_t                   req_i,
  input  frba_pkg::align_cfg_t             cfg_i,
  input  logic [SLOT_W-1:0]                slot_i,
  input  logic [FILL_W-1:0]                fill_i,
  input  logic [frba_pkg::SIZE_W-1:0]      count_i,
  input  logic [FILL_W-1:0]                last_i,
  input  logic [FILL_W-1:0]                peak_i,
  output logic [SLOT_W-1:0]                slot_o,
  output logic [FILL_W-1:0]                fill_o,
  output logic [frba_pkg::SIZE_W-1:0]      count_o,
  output logic [FILL_W-1:0]                last_o,
  output logic [FILL_W-1:0]                peak_o,
  output frba_pkg::res_t                   res_o
);

  localparam int unsigned WIDE_W = ((FILL_W > frba_pkg::SIZE_W) ? FILL_W
                                                                : frba_pkg::SIZE_W) + 2;
  localparam int unsigned OFFS_W = FILL_W + 2;

  logic [frba_pkg::ALIGN_W-1:0] align_sel;
  logic [frba_pkg::ALIGN_W-1:0] align_mask;
  logic [WIDE_W-1:0]            aligned;
  logic [WIDE_W-1:0]            alloc_end;
  logic [frba_pkg::SIZE_W-1:0]  size_eff;
  logic                         overflow;
  logic                         shrink_err;
  logic [OFFS_W-1:0]            handle;
  logic [frba_pkg::HANDLE_W-1:0] handle_out;
  frba_pkg::status_e            status;

  always_comb begin
    case (req_i.align_kind)
      frba_pkg::KIND_VERTEX:   align_sel = cfg_i.vertex_align;
      frba_pkg::KIND_INDEX:    align_sel = cfg_i.index_align;
      frba_pkg::KIND_CONSTANT: align_sel = cfg_i.constant_align;
      default:                 align_sel = req_i.custom_align;
    endcase
  end

  // An alignment of zero behaves as one, so its mask is empty.
  assign align_mask = (align_sel == '0) ? '0 : align_sel - 1'b1;
  assign aligned    = (WIDE_W'(fill_i) + WIDE_W'(align_mask)) & ~WIDE_W'(align_mask);
  assign size_eff   = (req_i.size_bytes == '0) ? frba_pkg::SIZE_W'(1) : req_i.size_bytes;
  assign alloc_end  = aligned + WIDE_W'(size_eff);
  assign overflow   = alloc_end > WIDE_W'(REGION_BYTES);
  assign shrink_err = WIDE_W'(req_i.size_bytes) > WIDE_W'(last_i);
  assign handle     = OFFS_W'(slot_i) * OFFS_W'(REGION_BYTES) + OFFS_W'(aligned);

  always_comb begin
    slot_o     = slot_i;
    fill_o     = fill_i;
    count_o    = count_i;
    last_o     = last_i;
    peak_o     = peak_i;
    status     = frba_pkg::STATUS_OK;
    handle_out = '0;
    case (req_i.op)
      frba_pkg::OP_ALLOC: begin
        if (overflow) begin
          status = frba_pkg::STATUS_OVERFLOW;
        end else begin
          last_o     = FILL_W'(size_eff);
          fill_o     = FILL_W'(alloc_end);
          count_o    = (count_i == '1) ? count_i : count_i + 1'b1;
          handle_out = frba_pkg::HANDLE_W'(handle);
        end
      end
      frba_pkg::OP_SHRINK: begin
        if (shrink_err) begin
          status = frba_pkg::STATUS_SHRINK;
        end else begin
          fill_o = fill_i - last_i + FILL_W'(req_i.size_bytes);
          last_o = FILL_W'(req_i.size_bytes);
        end
      end
      frba_pkg::OP_SWAP: begin
        peak_o  = (fill_i > peak_i) ? fill_i : peak_i;
        slot_o  = (slot_i == SLOT_W'(REGION_COUNT - 1)) ? '0 : slot_i + 1'b1;
        fill_o  = '0;
        count_o = '0;
        last_o  = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.handle_offset = handle_out;
    res_o.status        = status;
    res_o.frame_slot    = frba_pkg::SLOT_O_W'(slot_o);
    res_o.fill_bytes    = frba_pkg::SIZE_W'(fill_o);
    res_o.peak_bytes    = frba_pkg::SIZE_W'(peak_o);
    res_o.alloc_count   = count_o;
  end

endmodule

// File: rtl/core/frame_ring_bump_allocator_core.sv
// Channel   Dir  Handshake                       Contents
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  one request: op, kind, alignment, size
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  one result for every request
// cfg       in   cfg_we_i                         alignment register write, no wait
//
// One item per cycle is sustained while m_axis_tready_i is high; each result passes
// through the input register and then the result register before it is presented.
// The fill, count, last size, peak and slot registers are updated in the same cycle that
// an item moves to the result register, which is the loop that sets that rate.
// Reset zeroes the valid flags and the slot, fill, count, last size and peak registers
// (not the input or result registers) and loads alignment with 32, 16 and 256.
// While m_axis_tready_i is low the result holds and one more item is taken into the
// input register; the input side then stalls.
module frame_ring_bump_allocator_core #(
  parameter int unsigned REGION_BYTES = 1048576,
  parameter int unsigned REGION_COUNT = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [frba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [frba_pkg::ALIGN_W-1:0]   cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // custom_align[12:0], size_bytes[33:13], zero fill above
  input  logic [39:0]                    s_axis_tdata_i,
  // op[1:0], align_kind[3:2]
  input  logic [3:0]                     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // handle_offset[21:0], frame_slot[23:22], fill_bytes[44:24], peak_bytes[65:45],
  // alloc_count[86:66], zero fill above
  output logic [87:0]                    m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]                     m_axis_tuser_o
);

  localparam int unsigned FILL_W = $clog2(REGION_BYTES + 1);
  localparam int unsigned SLOT_W = $clog2(REGION_COUNT);

  frba_pkg::align_cfg_t cfg;
  frba_pkg::req_t       req_in;
  frba_pkg::req_t       req_q;
  frba_pkg::res_t       res_d, res_q;
  logic                 in_valid_q, in_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic                 advance;

  logic [SLOT_W-1:0]           slot_q, slot_d;
  logic [FILL_W-1:0]           fill_q, fill_d;
  logic [frba_pkg::SIZE_W-1:0] count_q, count_d;
  logic [FILL_W-1:0]           last_q, last_d;
  logic [FILL_W-1:0]           peak_q, peak_d;

  frba_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  always_comb begin
    req_in.op           = frba_pkg::op_e'(s_axis_tuser_i[1:0]);
    req_in.align_kind   = frba_pkg::kind_e'(s_axis_tuser_i[3:2]);
    req_in.custom_align = s_axis_tdata_i[12:0];
    req_in.size_bytes   = s_axis_tdata_i[33:13];
  end

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  frba_step_logic #(
    .REGION_BYTES (REGION_BYTES),
    .REGION_COUNT (REGION_COUNT)
  ) u_step (
    .req_i   (req_q),
    .cfg_i   (cfg),
    .slot_i  (slot_q),
    .fill_i  (fill_q),
    .count_i (count_q),
    .last_i  (last_q),
    .peak_i  (peak_q),
    .slot_o  (slot_d),
    .fill_o  (fill_d),
    .count_o (count_d),
    .last_o  (last_d),
    .peak_o  (peak_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
      fill_q      <= '0;
      count_q     <= '0;
      last_q      <= '0;
      peak_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        slot_q  <= slot_d;
        fill_q  <= fill_d;
        count_q <= count_d;
        last_q  <= last_d;
        peak_q  <= peak_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      req_q <= req_in;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.status;
  assign m_axis_tdata_o  = {1'b0, res_q.alloc_count, res_q.peak_bytes, res_q.fill_bytes,
                            res_q.frame_slot, res_q.handle_offset};

  // A failed or non-allocating step never hands out an offset.
  a_err_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status != frba_pkg::STATUS_OK) |-> (res_q.handle_offset == '0))
    else $error("error result carries a nonzero offset");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < REGION_COUNT)
    else $error("slot index beyond region count");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(fill_q) <= REGION_BYTES) && (last_q <= fill_q))
    else $error("region fill out of range");

  a_swap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && req_q.op == frba_pkg::OP_SWAP) |=> (fill_q == '0 && count_q == '0))
    else $error("swap did not clear the new region");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(fill_q) && $stable(slot_q) && $stable(count_q)))
    else $error("state changed without an item moving");

endmodule
